FILE: rtl/lst_pkg.sv
`default_nettype none
package lst_pkg;

    localparam int SENSOR_COUNT  = 6;
    localparam int ERR_FRAC_BITS = 8;
    localparam int ERR_W         = 12;
    localparam int LEVEL_W       = 4;
    localparam int LIMIT_W       = 8;
    localparam int COUNT_W       = 3;
    localparam int IDX_W         = 3;
    localparam int WEIGHT_W      = 5;
    // |weight| <= 5 scaled by 2^F needs F+4 bits signed; one spare bit
    localparam int SCALED_W      = ERR_FRAC_BITS + WEIGHT_W;
    localparam int DIST_W        = SCALED_W + 1;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT    = 2'd3;

    localparam logic [LEVEL_W-1:0] RST_LEVEL_CEILING = 4'd4;
    localparam logic [LEVEL_W-1:0] RST_ON_THRESHOLD  = 4'd3;
    localparam logic [LEVEL_W-1:0] RST_OFF_THRESHOLD = 4'd1;
    localparam logic [LIMIT_W-1:0] RST_LOST_LIMIT    = 8'd10;

    localparam logic signed [WEIGHT_W-1:0] WEIGHTS [SENSOR_COUNT] =
        '{-5'sd5, -5'sd3, -5'sd1, 5'sd1, 5'sd3, 5'sd5};

    localparam logic signed [SCALED_W-1:0] ERR_HI = SCALED_W'(2047);
    localparam logic signed [SCALED_W-1:0] ERR_LO = -SCALED_W'(2048);

    typedef struct packed {
        logic [SENSOR_COUNT-1:0] filtered;
        logic [COUNT_W-1:0]      sensors_on;
        logic                    lost;
        logic                    split_line;
        logic                    wide_line;
        logic signed [ERR_W-1:0] track_error;
    } t_result;

    typedef struct packed {
        logic [LEVEL_W-1:0] ceiling;
        logic [LEVEL_W-1:0] on_thr;
        logic [LEVEL_W-1:0] off_thr;
    } t_lane_cfg;

    function automatic logic signed [SCALED_W-1:0] scale_weight(
        input logic signed [WEIGHT_W-1:0] w
    );
        logic signed [SCALED_W-1:0] ext;
        ext = {{(SCALED_W-WEIGHT_W){w[WEIGHT_W-1]}}, w};
        return ext <<< ERR_FRAC_BITS;
    endfunction

    function automatic logic signed [ERR_W-1:0] clamp_error(
        input logic signed [SCALED_W-1:0] v
    );
        logic signed [SCALED_W-1:0] c;
        if (v > ERR_HI) begin
            c = ERR_HI;
        end else if (v < ERR_LO) begin
            c = ERR_LO;
        end else begin
            c = v;
        end
        return c[ERR_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lst_lane.sv
`default_nettype none
module lst_lane
    import lst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_raw,
    input  wire t_lane_cfg i_cfg,
    output logic           o_filtered
);

    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic               r_bit;
    logic               n_bit;

    always_comb begin
        n_level = r_level;
        if (i_raw) begin
            if (r_level < i_cfg.ceiling) begin
                n_level = r_level + 1'b1;
            end
        end else if (r_level != '0) begin
            n_level = r_level - 1'b1;
        end
        // on test wins where the thresholds overlap
        n_bit = r_bit;
        if (n_level >= i_cfg.on_thr) begin
            n_bit = 1'b1;
        end else if (n_level <= i_cfg.off_thr) begin
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_bit   <= 1'b0;
        end else if (i_en) begin
            r_level <= n_level;
            r_bit   <= n_bit;
        end
    end

    assign o_filtered = r_bit;

endmodule
`default_nettype wire

FILE: rtl/lst_merge.sv
`default_nettype none
module lst_merge
    import lst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic [SENSOR_COUNT-1:0] i_mask,
    input  wire logic [LIMIT_W-1:0]      i_lost_limit,
    output t_result                      o_result
);

    logic signed [ERR_W-1:0]    r_prev_err;
    logic signed [ERR_W-1:0]    n_prev_err;
    logic [LIMIT_W-1:0]         r_empty_run;
    logic [LIMIT_W-1:0]         n_empty_run;

    logic [SENSOR_COUNT-1:0]    starts;
    logic [COUNT_W-1:0]         cnt;
    logic [COUNT_W-1:0]         run_cnt;
    logic [IDX_W-1:0]           first_idx;
    logic [IDX_W-1:0]           last_idx;
    logic [WEIGHT_W-1:0]        idx_sum;
    logic signed [WEIGHT_W-1:0] mean_w;
    logic signed [DIST_W-1:0]   prev_ext;
    logic signed [SCALED_W-1:0] scaled [SENSOR_COUNT];
    logic signed [DIST_W-1:0]   diff   [SENSOR_COUNT];
    logic [DIST_W-1:0]          gap    [SENSOR_COUNT];
    logic                       found;
    logic [DIST_W-1:0]          best_dist;
    logic signed [SCALED_W-1:0] best_w;
    logic signed [ERR_W-1:0]    err;
    logic                       split;

    // a run starts at a set bit whose lower neighbor is clear
    assign starts = i_mask & ~{i_mask[SENSOR_COUNT-2:0], 1'b0};
    assign prev_ext = {{(DIST_W-ERR_W){r_prev_err[ERR_W-1]}}, r_prev_err};

    always_comb begin
        cnt       = '0;
        run_cnt   = '0;
        first_idx = '0;
        last_idx  = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            cnt     = cnt + COUNT_W'(i_mask[i]);
            run_cnt = run_cnt + COUNT_W'(starts[i]);
            if (i_mask[i]) begin
                last_idx = IDX_W'(i);
            end
        end
        for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // weights are 2i-5, so the mean over one run is first+last-5 exactly
    assign idx_sum = {2'b00, first_idx} + {2'b00, last_idx};
    assign mean_w  = $signed(idx_sum - WEIGHT_W'(5));
    assign split   = run_cnt >= COUNT_W'(2);

    always_comb begin
        found     = 1'b0;
        best_dist = '0;
        best_w    = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            scaled[i] = scale_weight(WEIGHTS[i]);
            diff[i]   = {scaled[i][SCALED_W-1], scaled[i]} - prev_ext;
            gap[i]    = diff[i][DIST_W-1] ? DIST_W'(-diff[i]) : DIST_W'(diff[i]);
            // strict compare keeps the lowest index on ties
            if (i_mask[i] && (!found || gap[i] < best_dist)) begin
                found     = 1'b1;
                best_dist = gap[i];
                best_w    = scaled[i];
            end
        end
    end

    always_comb begin
        n_prev_err  = r_prev_err;
        n_empty_run = r_empty_run;
        o_result.filtered   = i_mask;
        o_result.sensors_on = cnt;
        o_result.lost       = 1'b0;
        o_result.split_line = 1'b0;
        o_result.wide_line  = 1'b0;
        err = r_prev_err;
        if (cnt == '0) begin
            if (r_empty_run < i_lost_limit) begin
                n_empty_run = r_empty_run + 1'b1;
            end
            o_result.lost = n_empty_run >= i_lost_limit;
        end else begin
            n_empty_run         = '0;
            o_result.split_line = split;
            o_result.wide_line  = cnt >= COUNT_W'(4);
            if (split) begin
                err = clamp_error(best_w);
            end else begin
                err = clamp_error(scale_weight(mean_w));
            end
            n_prev_err = err;
        end
        o_result.track_error = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_empty_run <= RST_LOST_LIMIT;
        end else if (i_en) begin
            r_prev_err  <= n_prev_err;
            r_empty_run <= n_empty_run;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/line_sensor_tracking_error.sv
// A sample accepted while not stalled updates the six filter lanes; the merge stage
// then fills the output register once that register is empty or not stalled.
// No new sample is taken until that handoff: o_stall stays high while one is held.
// Reset (i_rst_n low, synchronous): levels and held bits cleared, lost run set to its
// limit of 10, configuration registers to 4/3/1/10, output register empty.
`default_nettype none
module line_sensor_tracking_error
    import lst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [SENSOR_COUNT-1:0] i_raw_sensors,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [SENSOR_COUNT-1:0]      o_filtered_sensors,
    output logic [COUNT_W-1:0]           o_sensors_on,
    output logic                         o_line_lost,
    output logic                         o_split_line,
    output logic                         o_wide_line,
    output logic signed [ERR_W-1:0]      o_track_error,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [LIMIT_W-1:0]      i_cfg_data
);

    t_lane_cfg               r_lane_cfg;
    logic [LIMIT_W-1:0]      r_lost_limit;
    logic                    r_busy;
    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 merged;
    logic [SENSOR_COUNT-1:0] mask;
    logic                    in_take;
    logic                    merge_go;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy;
    assign in_take     = i_valid && !r_busy;
    assign merge_go    = r_busy && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_cfg.ceiling <= RST_LEVEL_CEILING;
            r_lane_cfg.on_thr  <= RST_ON_THRESHOLD;
            r_lane_cfg.off_thr <= RST_OFF_THRESHOLD;
            r_lost_limit       <= RST_LOST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEVEL_CEILING: r_lane_cfg.ceiling <= i_cfg_data[LEVEL_W-1:0];
                CFG_ON_THRESHOLD:  r_lane_cfg.on_thr  <= i_cfg_data[LEVEL_W-1:0];
                CFG_OFF_THRESHOLD: r_lane_cfg.off_thr <= i_cfg_data[LEVEL_W-1:0];
                CFG_LOST_LIMIT:    r_lost_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lst_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (in_take),
            .i_raw      (i_raw_sensors[g]),
            .i_cfg      (r_lane_cfg),
            .o_filtered (mask[g])
        );
    end

    lst_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (merge_go),
        .i_mask       (mask),
        .i_lost_limit (r_lost_limit),
        .o_result     (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // hold busy until the merge stage hands the item to the output
            if (in_take) begin
                r_busy <= 1'b1;
            end else if (merge_go) begin
                r_busy <= 1'b0;
            end
            if (merge_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (merge_go) begin
            r_out <= merged;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_filtered_sensors = r_out.filtered;
    assign o_sensors_on       = r_out.sensors_on;
    assign o_line_lost        = r_out.lost;
    assign o_split_line       = r_out.split_line;
    assign o_wide_line        = r_out.wide_line;
    assign o_track_error      = r_out.track_error;

endmodule
`default_nettype wire

FILE: rtl/lst_checker.sv
`default_nettype none
module lst_checker
    import lst_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic [SENSOR_COUNT-1:0] o_filtered_sensors,
    input wire logic [COUNT_W-1:0]      o_sensors_on,
    input wire logic                    o_line_lost,
    input wire logic                    o_split_line,
    input wire logic                    o_wide_line,
    input wire logic signed [ERR_W-1:0] o_track_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_track_error)
            && $stable(o_filtered_sensors))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(o_filtered_sensors) == 32'(o_sensors_on))
        else $error("sensors_on does not match filtered bits");

    a_lost_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_lost |-> o_filtered_sensors == '0 && !o_split_line
            && !o_wide_line)
        else $error("line lost with sensors set");

    a_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_wide_line == (o_sensors_on >= COUNT_W'(4)))
        else $error("wide flag disagrees with count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken before merge");

endmodule

bind line_sensor_tracking_error lst_checker u_lst_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_filtered_sensors (o_filtered_sensors),
    .o_sensors_on       (o_sensors_on),
    .o_line_lost        (o_line_lost),
    .o_split_line       (o_split_line),
    .o_wide_line        (o_wide_line),
    .o_track_error      (o_track_error)
);
`default_nettype wire
